// File: rtl/ascii_signed_integer_parser_unit_macros.svh
// Assertion macros for the ASCII signed integer parser unit.
// Used by the top level only; expects signals named clock and reset in scope.
`ifndef ASCII_SIGNED_INTEGER_PARSER_UNIT_MACROS_SVH
`define ASCII_SIGNED_INTEGER_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASIPU_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("asipu: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define ASIPU_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("asipu: next-cycle check failed");

`endif

// File: rtl/asipu_pkg.sv
// Package for the ASCII signed integer parser unit: parse phase type,
// character and radix codes, digit decoding. No dependencies.
package asipu_pkg;

   typedef enum logic [5:0] {
      PH_LEAD   = 6'b000001,
      PH_SIGNED = 6'b000010,
      PH_ZERO   = 6'b000100,
      PH_ZEROX  = 6'b001000,
      PH_DIGITS = 6'b010000,
      PH_DONE   = 6'b100000
   } phase_type;

   typedef struct packed {
      logic       valid;
      logic [5:0] value;
   } digit_type;

   localparam logic [7:0] CHAR_SPACE   = 8'd32;
   localparam logic [7:0] CHAR_PLUS    = 8'd43;
   localparam logic [7:0] CHAR_MINUS   = 8'd45;
   localparam logic [7:0] CHAR_ZERO    = 8'd48;
   localparam logic [7:0] CHAR_NINE    = 8'd57;
   localparam logic [7:0] CHAR_UPPER_A = 8'd65;
   localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
   localparam logic [7:0] CHAR_UPPER_X = 8'd88;
   localparam logic [7:0] CHAR_LOWER_A = 8'd97;
   localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
   localparam logic [7:0] CHAR_LOWER_X = 8'd120;
   localparam logic [7:0] LETTER_BIAS  = 8'd10;

   localparam logic [5:0] BASE_AUTO    = 6'd0;
   localparam logic [5:0] BASE_MIN     = 6'd2;
   localparam logic [5:0] BASE_OCT     = 6'd8;
   localparam logic [5:0] BASE_DEC     = 6'd10;
   localparam logic [5:0] BASE_HEX     = 6'd16;
   localparam logic [5:0] BASE_MAX     = 6'd36;

   function automatic digit_type digit_of(input logic [7:0] c);
      digit_type d;
      d.valid = 1'b1;
      d.value = '0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         d.value = 6'(c - CHAR_ZERO);
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         d.value = 6'(c - CHAR_LOWER_A + LETTER_BIAS);
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         d.value = 6'(c - CHAR_UPPER_A + LETTER_BIAS);
      end else begin
         d.valid = 1'b0;
      end
      return d;
   endfunction

   function automatic logic digit_ok(input logic [7:0] c, input logic [5:0] base);
      digit_type d;
      d = digit_of(c);
      return (base >= BASE_MIN) && (base <= BASE_MAX) && d.valid && (d.value < base);
   endfunction

endpackage

// File: rtl/ascii_signed_integer_parser_unit.sv
// ASCII signed integer parser unit: strtol-style conversion, one character per item.
// Depends on asipu_pkg and ascii_signed_integer_parser_unit_macros.svh.
//
// Usage:
//  - req channel carries one string character per item in req_tdata and a
//    first-character flag in req_tuser; the flag restarts the parse and latches
//    the radix from the csr register (0 = detect from prefix, else 2..36).
//  - rsp channel carries one result per string: the signed 64-bit value and
//    the end offset in rsp_tdata, the converted flag in rsp_tuser. The result
//    is produced by the character that ends the number (NUL included);
//    characters after it are dropped until the next first-character mark.
//  - The ending character's result enters the result register (or the skid
//    register) at its accepting edge. Throughput: one character per cycle
//    while req_tready is high; the single multiply-add of the accumulator by
//    the radix lies in the feedback path of the parse state registers.
//  - Stall: a two-entry output stage (result register plus skid register)
//    keeps taking characters while one result waits; req_tready drops only
//    when both entries are full.
//  - Reset: synchronous, active high; clears the parse state, empties the
//    output stage and sets the radix register to 10.
//  - csr writes are taken at any edge outside reset with csr_wr_en high and
//    apply from the next first-character mark.
`include "ascii_signed_integer_parser_unit_macros.svh"

module ascii_signed_integer_parser_unit
   import asipu_pkg::*;
#(
   parameter int OFFSET_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wr_en,
   input  logic [5:0]  csr_wr_data,   // number_base
   // character stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,     // [7:0] character
   input  logic        req_tuser,     // [0] first_char
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,     // [63:0] value, [79:64] end_offset
   output logic        rsp_tuser      // [0] converted
);

   // Positions saturate at 2^OFFSET_BITS-1, capped at 16 bits.
   localparam int POS_BITS = (OFFSET_BITS < 16) ? OFFSET_BITS : 16;
   localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

   // Parse state
   logic [5:0]          number_base_ff;
   phase_type           phase_ff, phase_in;
   logic [63:0]         acc_ff, acc_in;
   logic                neg_ff, neg_in;
   logic [5:0]          base_ff, base_in;
   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic [POS_BITS-1:0] pfx_ff, pfx_in;

   // Output stage
   logic                rsp_valid_ff, skid_valid_ff;
   logic [79:0]         rsp_data_ff, skid_data_ff;
   logic                rsp_user_ff, skid_user_ff;

   // Step logic
   logic                accept, pop, push;
   phase_type           ph;
   logic                neg;
   logic [5:0]          base, start_base;
   logic [POS_BITS-1:0] pos;
   digit_type           dig;
   logic [63:0]         acc_mul, finish_value;
   logic                emit;
   logic [63:0]         res_value;
   logic [15:0]         res_off;
   logic                res_conv;

   assign accept     = req_tvalid && req_tready;
   assign pop        = rsp_valid_ff && rsp_tready;
   assign push       = accept && emit;
   assign req_tready = !skid_valid_ff;

   assign dig          = digit_of(req_tdata);
   // DIGITS is never entered with a restart, so the registered state is current.
   assign acc_mul      = acc_ff * {58'd0, base_ff};
   assign finish_value = neg_ff ? (64'd0 - acc_ff) : acc_ff;

   always_comb begin
      // A first-character mark restarts the parse before this character.
      ph         = req_tuser ? PH_LEAD : phase_ff;
      neg        = req_tuser ? 1'b0 : neg_ff;
      base       = req_tuser ? number_base_ff : base_ff;
      pos        = req_tuser ? '0 : pos_ff;
      start_base = (base == BASE_AUTO) ? BASE_DEC : base;

      phase_in  = ph;
      acc_in    = acc_ff;
      neg_in    = neg;
      base_in   = base;
      pfx_in    = pfx_ff;
      emit      = 1'b0;
      res_value = finish_value;
      res_off   = 16'(pos);
      res_conv  = 1'b1;

      case (ph)
         PH_LEAD, PH_SIGNED: begin
            if (ph == PH_LEAD && req_tdata == CHAR_SPACE) begin
               // skip leading space
            end else if (ph == PH_LEAD && req_tdata == CHAR_MINUS) begin
               neg_in   = 1'b1;
               phase_in = PH_SIGNED;
            end else if (ph == PH_LEAD && req_tdata == CHAR_PLUS) begin
               phase_in = PH_SIGNED;
            end else if (req_tdata == CHAR_ZERO
                         && (base == BASE_AUTO || base == BASE_HEX)) begin
               // leading zero: may open a hex or octal prefix
               acc_in   = '0;
               phase_in = PH_ZERO;
            end else begin
               base_in = start_base;
               if (digit_ok(req_tdata, start_base)) begin
                  acc_in   = {58'd0, dig.value};
                  phase_in = PH_DIGITS;
               end else begin
                  // nothing converted
                  emit      = 1'b1;
                  phase_in  = PH_DONE;
                  res_value = '0;
                  res_off   = '0;
                  res_conv  = 1'b0;
               end
            end
         end
         PH_ZERO: begin
            if (req_tdata == CHAR_LOWER_X || req_tdata == CHAR_UPPER_X) begin
               pfx_in   = pos;
               phase_in = PH_ZEROX;
            end else if (base == BASE_AUTO) begin
               if (req_tdata >= CHAR_ZERO && req_tdata <= CHAR_NINE) begin
                  base_in = BASE_OCT;
                  if (digit_ok(req_tdata, BASE_OCT)) begin
                     acc_in   = {58'd0, dig.value};
                     phase_in = PH_DIGITS;
                  end else begin
                     emit     = 1'b1;
                     phase_in = PH_DONE;
                  end
               end else begin
                  emit     = 1'b1;
                  phase_in = PH_DONE;
               end
            end else if (digit_ok(req_tdata, base)) begin
               acc_in   = {58'd0, dig.value};
               phase_in = PH_DIGITS;
            end else begin
               emit     = 1'b1;
               phase_in = PH_DONE;
            end
         end
         PH_ZEROX: begin
            if (digit_ok(req_tdata, BASE_HEX)) begin
               base_in  = BASE_HEX;
               acc_in   = {58'd0, dig.value};
               phase_in = PH_DIGITS;
            end else begin
               // "0x" without a hex digit: the zero alone is the number
               emit     = 1'b1;
               phase_in = PH_DONE;
               res_off  = 16'(pfx_ff);
            end
         end
         PH_DIGITS: begin
            if (digit_ok(req_tdata, base)) begin
               acc_in = acc_mul + {58'd0, dig.value};
            end else begin
               emit     = 1'b1;
               phase_in = PH_DONE;
            end
         end
         PH_DONE: begin
            // drop characters until the next first-character mark
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase

      pos_in = (pos != POS_MAX) ? POS_BITS'(pos + 1'b1) : pos;
   end

   // Parse state registers: advance on every accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         number_base_ff <= BASE_DEC;
         phase_ff       <= PH_LEAD;
         acc_ff         <= '0;
         neg_ff         <= 1'b0;
         base_ff        <= BASE_AUTO;
         pos_ff         <= '0;
         pfx_ff         <= '0;
      end else begin
         if (csr_wr_en) begin
            number_base_ff <= csr_wr_data;
         end
         if (accept) begin
            phase_ff <= phase_in;
            acc_ff   <= acc_in;
            neg_ff   <= neg_in;
            base_ff  <= base_in;
            pos_ff   <= pos_in;
            pfx_ff   <= pfx_in;
         end
      end
   end

   // Output stage: result register with a skid entry behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (pop || !rsp_valid_ff) begin
            if (skid_valid_ff) begin
               rsp_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               rsp_valid_ff <= push;
            end
         end else if (push) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop || !rsp_valid_ff) begin
         if (skid_valid_ff) begin
            rsp_data_ff <= skid_data_ff;
            rsp_user_ff <= skid_user_ff;
         end else if (push) begin
            rsp_data_ff <= {res_off, res_value};
            rsp_user_ff <= res_conv;
         end
      end else if (push) begin
         skid_data_ff <= {res_off, res_value};
         skid_user_ff <= res_conv;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Assertions
   `ASIPU_ASSERT_NOW(a_skid_behind_result, skid_valid_ff, rsp_valid_ff)
   `ASIPU_ASSERT_NEXT(a_result_ends_string, push, phase_ff == PH_DONE)
   `ASIPU_ASSERT_NEXT(a_position_advances, accept && !req_tuser && pos_ff != POS_MAX, pos_ff == POS_BITS'($past(pos_ff) + 1'b1))

endmodule
